// ----- rtl/ewts_pkg.sv -----
// shared constants for the earliest wakeup task scheduler
// no dependencies; used by earliest_wakeup_task_scheduler_top
package ewts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam int MODE_W   = 2;
  localparam int NOW_W    = 63;
  localparam int DELAY_W  = 32;
  localparam int DL_W     = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;
  localparam int WAIT_W   = 32;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [DL_W-1:0]     deadline_t;

  localparam mode_t MODE_CREATE = 2'd0;
  localparam mode_t MODE_DELAY  = 2'd1;
  localparam mode_t MODE_EXIT   = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_NO_TASK = 2'd2;

endpackage

// ----- rtl/earliest_wakeup_task_scheduler_top.sv -----
// earliest wakeup task scheduler: slot table, deadline memory and linear scan
// depends on ewts_pkg
//
// usage
//   input channel in_valid/in_stall carries mode, now_ms and delay_ms; a
//   transaction is taken when in_valid is high and in_stall is low. every
//   transaction gives exactly one result transaction on out_valid/out_stall
//   (status, slot, wait_ms, switch_task).
//   create and the unused mode go to a short step that loads the result into
//   the output register; the block then returns to idle for the next one.
//   delay and exit write the running task's deadline into the deadline memory,
//   then scan all TASK_SLOTS entries through its single read port (one read per
//   cycle, registered read); a final step loads the result into the output
//   register, and the block then returns to idle for the next transaction.
//   one transaction is in progress at a time; in_stall is high from acceptance
//   until the result is loaded into the output register. when the receiver
//   stalls, the result holds in the output register and the block waits in its
//   final step until the register frees up.
//   reset (rst_n low, synchronous) marks slot 0 active, all others inactive,
//   all deadlines zero and running slot zero; per-entry valid bits make
//   unwritten deadlines read as zero, so no clearing pass is needed.
module earliest_wakeup_task_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [62:0] in_now_ms,
  input  logic [31:0] in_delay_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [31:0] out_wait_ms,
  output logic        out_switch_task
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHORT = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int N = ewts_pkg::TASK_SLOTS;

  logic [2:0]                       state_r, state_nxt;
  logic [N-1:0]                     act_r, act_nxt;
  logic [N-1:0]                     dl_vld_r, dl_vld_nxt;
  ewts_pkg::idx_t                   run_r, run_nxt;

  ewts_pkg::mode_t                  mode_r;
  logic [ewts_pkg::NOW_W-1:0]       now_r;
  logic [ewts_pkg::DELAY_W-1:0]     delay_r;

  ewts_pkg::deadline_t              dl_mem [N];
  ewts_pkg::deadline_t              mem_q_r;
  logic                             mem_we;
  ewts_pkg::deadline_t              mem_wdata;

  logic [ewts_pkg::CNT_W-1:0]       iss_r, iss_nxt;
  logic                             rvld_r, rvld_nxt;
  ewts_pkg::idx_t                   tag_r, tag_nxt;
  logic                             issue;

  logic                             found_r, found_nxt;
  ewts_pkg::idx_t                   best_r, best_nxt;
  ewts_pkg::deadline_t              best_dl_r, best_dl_nxt;
  ewts_pkg::deadline_t              cur_dl;

  logic                             free_found;
  ewts_pkg::idx_t                   free_idx;

  ewts_pkg::deadline_t              now_ext;
  ewts_pkg::deadline_t              diff;
  logic [ewts_pkg::WAIT_W-1:0]      wait_val;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;
  logic                             out_load;
  ewts_pkg::status_t                o_status_r, o_status_nxt;
  logic [ewts_pkg::SLOT_W-1:0]      o_slot_r, o_slot_nxt;
  logic [ewts_pkg::WAIT_W-1:0]      o_wait_r, o_wait_nxt;
  logic                             o_sw_r, o_sw_nxt;

  logic                             in_acc;

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_slot        = o_slot_r;
  assign out_wait_ms     = o_wait_r;
  assign out_switch_task = o_sw_r;
  assign out_free        = !out_valid_r || !out_stall;

  assign now_ext   = {1'b0, now_r};
  assign mem_wdata = now_ext + ewts_pkg::DL_W'(delay_r);
  assign mem_we    = (state_r == S_WRITE);
  assign issue     = (state_r == S_SCAN) && (iss_r < ewts_pkg::CNT_W'(N));
  assign cur_dl    = dl_vld_r[tag_r] ? mem_q_r : '0;
  assign diff      = best_dl_r - now_ext;

  // lowest inactive slot for create
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_idx   = ewts_pkg::IDX_W'(i);
      end
    end
  end

  // saturate the distance to the chosen deadline at 32 bits
  always_comb begin
    if (best_dl_r > now_ext) begin
      wait_val = (|diff[ewts_pkg::DL_W-1:ewts_pkg::WAIT_W]) ? '1 : diff[ewts_pkg::WAIT_W-1:0];
    end else begin
      wait_val = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    dl_vld_nxt    = dl_vld_r;
    run_nxt       = run_r;
    iss_nxt       = iss_r;
    rvld_nxt      = 1'b0;
    tag_nxt       = tag_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_dl_nxt   = best_dl_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    o_status_nxt  = o_status_r;
    o_slot_nxt    = o_slot_r;
    o_wait_nxt    = o_wait_r;
    o_sw_nxt      = o_sw_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == ewts_pkg::MODE_DELAY || in_mode == ewts_pkg::MODE_EXIT) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SHORT;
          end
        end
      end
      S_SHORT: begin
        if (out_free) begin
          out_load     = 1'b1;
          state_nxt    = S_IDLE;
          o_status_nxt = ewts_pkg::ST_OK;
          o_slot_nxt   = '0;
          o_wait_nxt   = '0;
          o_sw_nxt     = 1'b0;
          if (mode_r == ewts_pkg::MODE_CREATE) begin
            if (free_found) begin
              act_nxt[free_idx]    = 1'b1;
              dl_vld_nxt[free_idx] = 1'b0;
              o_slot_nxt           = ewts_pkg::SLOT_W'(free_idx);
            end else begin
              o_status_nxt = ewts_pkg::ST_FULL;
            end
          end
        end
      end
      S_WRITE: begin
        dl_vld_nxt[run_r] = 1'b1;
        if (mode_r == ewts_pkg::MODE_EXIT) begin
          act_nxt[run_r] = 1'b0;
        end
        iss_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (issue) begin
          iss_nxt  = iss_r + 1'b1;
          rvld_nxt = 1'b1;
          tag_nxt  = iss_r[ewts_pkg::IDX_W-1:0];
        end
        if (rvld_r) begin
          if (act_r[tag_r] && (!found_r || cur_dl < best_dl_r)) begin
            found_nxt   = 1'b1;
            best_nxt    = tag_r;
            best_dl_nxt = cur_dl;
          end
          if (tag_r == ewts_pkg::IDX_W'(N - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (found_r) begin
            o_status_nxt = ewts_pkg::ST_OK;
            o_slot_nxt   = ewts_pkg::SLOT_W'(best_r);
            o_wait_nxt   = wait_val;
            o_sw_nxt     = (best_r != run_r);
            run_nxt      = best_r;
          end else begin
            o_status_nxt = ewts_pkg::ST_NO_TASK;
            o_slot_nxt   = '0;
            o_wait_nxt   = '0;
            o_sw_nxt     = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= N'(1);
      dl_vld_r    <= '0;
      run_r       <= '0;
      rvld_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      dl_vld_r    <= dl_vld_nxt;
      run_r       <= run_nxt;
      rvld_r      <= rvld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      now_r   <= in_now_ms;
      delay_r <= in_delay_ms;
    end
    tag_r      <= tag_nxt;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    o_status_r <= o_status_nxt;
    o_slot_r   <= o_slot_nxt;
    o_wait_r   <= o_wait_nxt;
    o_sw_r     <= o_sw_nxt;
  end

  // deadline memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dl_mem[run_r] <= mem_wdata;
    end
    mem_q_r <= dl_mem[iss_r[ewts_pkg::IDX_W-1:0]];
  end

  a_found_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && found_r) |-> act_r[best_r])
    else $error("chosen slot is not active");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE || $past(state_r) == S_SHORT))
    else $error("result appeared outside a finishing step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start work");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rvld_r && $past(issue))
      |-> (tag_r == $past(iss_r[ewts_pkg::IDX_W-1:0])))
    else $error("scan read tag out of step with issue pointer");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for earliest_wakeup_task_scheduler_top
// depends on ewts_pkg and the scheduler rtl; the slot table is modeled here
`timescale 1ns / 100ps

module tb_top;

  localparam ewts_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam int RANDOM_CALLS = 1525;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 100;
  localparam logic [ewts_pkg::WAIT_W-1:0] WAIT_SAT = '1;

  typedef struct {
    ewts_pkg::mode_t                mode;
    logic [ewts_pkg::NOW_W-1:0]     now_ms;
    logic [ewts_pkg::DELAY_W-1:0]   delay_ms;
  } sched_call_t;

  typedef struct {
    ewts_pkg::status_t              status;
    logic [ewts_pkg::SLOT_W-1:0]    slot;
    logic [ewts_pkg::WAIT_W-1:0]    wait_ms;
    logic                           switch_task;
  } sched_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [ewts_pkg::MODE_W-1:0]     in_mode = ewts_pkg::MODE_CREATE;
  logic [ewts_pkg::NOW_W-1:0]      in_now_ms = '0;
  logic [ewts_pkg::DELAY_W-1:0]    in_delay_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ewts_pkg::STATUS_W-1:0]   out_status;
  logic [ewts_pkg::SLOT_W-1:0]     out_slot;
  logic [ewts_pkg::WAIT_W-1:0]     out_wait_ms;
  logic                            out_switch_task;

  earliest_wakeup_task_scheduler_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_now_ms       (in_now_ms),
    .in_delay_ms     (in_delay_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_wait_ms     (out_wait_ms),
    .out_switch_task (out_switch_task)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic                 task_live [ewts_pkg::TASK_SLOTS];
  ewts_pkg::deadline_t  wake_at [ewts_pkg::TASK_SLOTS];
  int                   run_slot;

  sched_call_t   sched_calls [$];
  sched_result_t sched_results [$];

  int  total_calls = 0;
  int  calls_taken = 0;
  int  results_checked = 0;
  int  error_count = 0;
  int  quiet_cycles = 0;
  int  mode_hits [4];
  int  full_hits = 0;
  int  no_task_hits = 0;
  int  saturated_hits = 0;
  int  switch_hits = 0;
  logic call_taken = 1'b0;

  // store the running task's deadline, then pick the earliest active slot
  function automatic sched_result_t schedule_next(logic [ewts_pkg::NOW_W-1:0] now_ms,
                                                  logic [ewts_pkg::DELAY_W-1:0] delay_ms);
    sched_result_t        r;
    ewts_pkg::deadline_t  best_dl;
    ewts_pkg::deadline_t  gap;
    logic                 found;
    int                   best;
    int                   prev;
    r = '{default: '0};
    prev = run_slot;
    best = 0;
    best_dl = '0;
    found = 1'b0;
    wake_at[prev] = ewts_pkg::deadline_t'(now_ms) + ewts_pkg::deadline_t'(delay_ms);
    for (int i = 0; i < ewts_pkg::TASK_SLOTS; i++) begin
      if (task_live[i] && (!found || wake_at[i] < best_dl)) begin
        found = 1'b1;
        best = i;
        best_dl = wake_at[i];
      end
    end
    if (!found) begin
      r.status = ewts_pkg::ST_NO_TASK;
      return r;
    end
    if (best_dl > ewts_pkg::deadline_t'(now_ms)) begin
      gap = best_dl - ewts_pkg::deadline_t'(now_ms);
      r.wait_ms = (gap > ewts_pkg::deadline_t'(WAIT_SAT)) ?
                  WAIT_SAT : gap[ewts_pkg::WAIT_W-1:0];
    end
    run_slot = best;
    r.status = ewts_pkg::ST_OK;
    r.slot = best[ewts_pkg::SLOT_W-1:0];
    r.switch_task = (best != prev);
    return r;
  endfunction

  function automatic sched_result_t scheduler_call(sched_call_t c);
    sched_result_t r;
    r = '{default: '0};
    case (c.mode)
      ewts_pkg::MODE_CREATE: begin
        r.status = ewts_pkg::ST_FULL;
        for (int i = 0; i < ewts_pkg::TASK_SLOTS; i++) begin
          if (!task_live[i] && r.status == ewts_pkg::ST_FULL) begin
            task_live[i] = 1'b1;
            wake_at[i] = '0;
            r.status = ewts_pkg::ST_OK;
            r.slot = i[ewts_pkg::SLOT_W-1:0];
          end
        end
      end
      ewts_pkg::MODE_DELAY: r = schedule_next(c.now_ms, c.delay_ms);
      ewts_pkg::MODE_EXIT: begin
        task_live[run_slot] = 1'b0;
        r = schedule_next(c.now_ms, '0);
      end
      default: r = '{default: '0};
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               $time, results_checked, what, got, want);
  endtask

  task automatic add_call(input ewts_pkg::mode_t mode,
                          input logic [ewts_pkg::NOW_W-1:0] now_ms,
                          input logic [ewts_pkg::DELAY_W-1:0] delay_ms);
    sched_call_t c;
    c.mode = mode;
    c.now_ms = now_ms;
    c.delay_ms = delay_ms;
    sched_calls.push_back(c);
  endtask

  function automatic logic [ewts_pkg::NOW_W-1:0] any_now();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ewts_pkg::NOW_W-1:0];
  endfunction

  // sender and receiver idle rates follow progress through the run
  function automatic int idle_pct(input bit receiver);
    if (calls_taken < total_calls / 3)
      return receiver ? 52 : 18;
    else if (calls_taken < (2 * total_calls) / 3)
      return receiver ? 18 : 52;
    return 0;
  endfunction

  always @(negedge clk) begin : driver
    sched_call_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !call_taken) begin
      // stalled transaction holds
    end else if (sched_calls.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
      c = sched_calls.pop_front();
      in_valid <= 1'b1;
      in_mode <= c.mode;
      in_now_ms <= c.now_ms;
      in_delay_ms <= c.delay_ms;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct(1'b1));
  end

  always @(posedge clk) begin : monitor
    sched_call_t   c;
    sched_result_t want;
    logic          fired;
    call_taken <= in_valid && !in_stall;
    if (rst_n) begin
      fired = 1'b0;
      if (in_valid && !in_stall) begin
        fired = 1'b1;
        c.mode = in_mode;
        c.now_ms = in_now_ms;
        c.delay_ms = in_delay_ms;
        want = scheduler_call(c);
        sched_results.push_back(want);
        calls_taken++;
        mode_hits[c.mode]++;
        if (want.status == ewts_pkg::ST_FULL) full_hits++;
        if (want.status == ewts_pkg::ST_NO_TASK) no_task_hits++;
        if (want.wait_ms == WAIT_SAT) saturated_hits++;
        if (want.switch_task) switch_hits++;
      end
      if (out_valid && !out_stall) begin
        fired = 1'b1;
        results_checked++;
        if (sched_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", 64'(out_status), 64'(0));
        end else begin
          want = sched_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_slot !== want.slot)
            report_mismatch("slot", 64'(out_slot), 64'(want.slot));
          if (out_wait_ms !== want.wait_ms)
            report_mismatch("wait_ms", 64'(out_wait_ms), 64'(want.wait_ms));
          if (out_switch_task !== want.switch_task)
            report_mismatch("switch_task", 64'(out_switch_task), 64'(want.switch_task));
        end
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d of %0d calls taken, %0d pending",
                 QUIET_LIMIT, calls_taken, total_calls, sched_results.size());
        $display("[earliest_wakeup_task_scheduler_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [ewts_pkg::NOW_W-1:0]    clock_ms;
    logic [ewts_pkg::NOW_W-1:0]    n_ms;
    logic [ewts_pkg::DELAY_W-1:0]  d_ms;
    ewts_pkg::mode_t               m;
    int                            pick;
    int                            create_pct;
    int                            exit_pct;

    for (int i = 0; i < ewts_pkg::TASK_SLOTS; i++) begin
      task_live[i] = (i == 0);
      wake_at[i] = '0;
    end
    run_slot = 0;
    for (int i = 0; i < 4; i++) mode_hits[i] = 0;

    // directed: lone task, empty table, inactive running slot, far deadline,
    // full table, ties, extremes and the unused mode
    add_call(ewts_pkg::MODE_DELAY, 63'd1000, 32'd5);
    add_call(ewts_pkg::MODE_EXIT, '0, '0);
    add_call(ewts_pkg::MODE_DELAY, 63'd5, 32'd3);
    add_call(ewts_pkg::MODE_CREATE, '0, '0);
    add_call(ewts_pkg::MODE_CREATE, '1, '1);
    add_call(ewts_pkg::MODE_DELAY, 63'h4000_0000_0000_0000, 32'd1);
    add_call(ewts_pkg::MODE_EXIT, 63'd3, 32'd77);
    add_call(ewts_pkg::MODE_CREATE, '0, '0);
    add_call(ewts_pkg::MODE_EXIT, 63'd10, '0);
    add_call(ewts_pkg::MODE_EXIT, 63'd10, '0);
    add_call(ewts_pkg::MODE_CREATE, '0, '0);
    add_call(ewts_pkg::MODE_DELAY, 63'd50, 32'd7);
    for (int i = 1; i < ewts_pkg::TASK_SLOTS; i++)
      add_call(ewts_pkg::MODE_CREATE, any_now(), $urandom);
    add_call(ewts_pkg::MODE_CREATE, '0, '0);
    add_call(ewts_pkg::MODE_DELAY, '1, '1);
    add_call(ewts_pkg::MODE_DELAY, 63'd20, '0);
    add_call(MODE_UNUSED, '1, '1);
    add_call(ewts_pkg::MODE_DELAY, '0, '0);
    add_call(ewts_pkg::MODE_EXIT, '1, '1);

    // random: a mostly advancing clock with occasional jumps and noise
    clock_ms = '0;
    create_pct = 25;
    exit_pct = 20;
    for (int n = 0; n < RANDOM_CALLS; n++) begin
      if (n % 100 == 0) begin
        create_pct = $urandom_range(10, 40);
        exit_pct = $urandom_range(10, 30);
      end
      pick = $urandom_range(99);
      if (pick < 4) m = MODE_UNUSED;
      else if (pick < 4 + create_pct) m = ewts_pkg::MODE_CREATE;
      else if (pick < 4 + create_pct + exit_pct) m = ewts_pkg::MODE_EXIT;
      else m = ewts_pkg::MODE_DELAY;
      pick = $urandom_range(99);
      if (pick < 85) begin
        clock_ms = clock_ms + ewts_pkg::NOW_W'($urandom_range(0, 40));
        n_ms = clock_ms;
      end else if (pick < 92) begin
        clock_ms = any_now();
        n_ms = clock_ms;
      end else begin
        n_ms = any_now();
      end
      pick = $urandom_range(99);
      if (pick < 55) d_ms = $urandom_range(0, 100);
      else if (pick < 75) d_ms = $urandom_range(0, 5000);
      else if (pick < 88) d_ms = $urandom;
      else if (pick < 94) d_ms = '0;
      else d_ms = '1;
      add_call(m, n_ms, d_ms);
    end
    total_calls = sched_calls.size();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (calls_taken < total_calls) @(negedge clk);
    while (sched_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d calls: %0d create, %0d delay, %0d exit, %0d unused; %0d results checked",
             calls_taken, mode_hits[ewts_pkg::MODE_CREATE], mode_hits[ewts_pkg::MODE_DELAY],
             mode_hits[ewts_pkg::MODE_EXIT], mode_hits[MODE_UNUSED], results_checked);
    $display("table full %0d, no runnable task %0d, saturated waits %0d, task switches %0d",
             full_hits, no_task_hits, saturated_hits, switch_hits);
    if (error_count == 0) begin
      $display("[earliest_wakeup_task_scheduler_top] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[earliest_wakeup_task_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
